[rtl/core/dtoi_pkg.sv]
// ============================================================================
// dtoi_pkg
// Shared types and constants for the decimal text to int16 parser.
// ============================================================================
package dtoi_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 16;
    // value*10+digit stays below 2**20
    localparam int PROD_W = 20;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [PROD_W-1:0] MAX_U16 = 20'd65535;
    localparam logic [NUM_W-1:0]  MAX_POS = 16'd32767;
    localparam logic [NUM_W-1:0]  MAX_NEG = 16'd32768;

    typedef struct packed {
        logic [NUM_W-1:0] acc;
        logic             failed;
        logic             negative;
        logic             at_start;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{acc: '0, failed: 1'b0, negative: 1'b0,
                                             at_start: 1'b1};

endpackage

[rtl/core/dtoi_char_step.sv]
// ============================================================================
// dtoi_char_step
// Next-state and result logic for one item of the parser.
// ============================================================================
module dtoi_char_step
    import dtoi_pkg::*;
(
    input  parse_state_t      st,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              end_mark,
    input  logic              signed_mode,
    output parse_state_t      st_next,
    output logic [NUM_W-1:0]  number_bits,
    output logic              parse_ok
);

    logic [PROD_W-1:0] acc_ext;
    logic [PROD_W-1:0] prod;
    logic [CHAR_W-1:0] digit;
    logic              is_digit;
    logic              ok;
    logic [NUM_W-1:0]  value;

    always_comb
    begin
        acc_ext  = {{(PROD_W-NUM_W){1'b0}}, st.acc};
        digit    = char_code - CHAR_ZERO;
        prod     = (acc_ext << 3) + (acc_ext << 1) + {{(PROD_W-CHAR_W){1'b0}}, digit};
        is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);

        st_next = st;
        ok      = !st.failed;
        value   = st.acc;

        if (!end_mark)
        begin
            st_next.at_start = 1'b0;
            if (!st.failed)
            begin
                if (st.at_start && signed_mode && (char_code == CHAR_MINUS))
                begin
                    st_next.negative = 1'b1;
                end
                else if (!is_digit)
                begin
                    st_next.failed = 1'b1;
                end
                else if (prod > MAX_U16)
                begin
                    st_next.failed = 1'b1;
                end
                else
                begin
                    st_next.acc = prod[NUM_W-1:0];
                end
            end
        end
        else
        begin
            st_next = PARSE_CLEAR;
            if (ok && signed_mode)
            begin
                if (st.at_start)
                begin
                    ok = 1'b0;
                end
                else if (st.negative)
                begin
                    if (st.acc > MAX_NEG)
                        ok = 1'b0;
                    else
                        value = NUM_W'(0) - st.acc;
                end
                else if (st.acc > MAX_POS)
                begin
                    ok = 1'b0;
                end
            end
        end

        number_bits = ok ? value : '0;
        parse_ok    = ok;
    end

endmodule

[rtl/core/decimal_text_to_int16.sv]
// ============================================================================
// decimal_text_to_int16
// Parses a stream of ASCII decimal characters into a 16-bit value.
// ============================================================================
// Usage:
//   Slave channel: one character per item in s_tdata, s_tlast high marks the
//   end of the string (s_tdata is then ignored). Each end item yields one
//   master item: the value in m_tdata and the success flag in m_tuser.
//   cfg_we/cfg_wdata write signed_mode (0 unsigned, 1 signed); write it only
//   while no string is in flight.
//   Path: an accepted end item lands in the input register, is evaluated
//   and captured in the result register, which raises m_tvalid; a waiting
//   result can hold it there. Throughput: one item per cycle while no end
//   item stalls, set by combinational multiply-by-ten and range compare.
//   Reset: signed_mode clears to unsigned, the parse state clears to an empty
//   string, both registers empty.
//   Stall: while m_tready is low and a result waits, character items keep
//   flowing; an end item holds in the input register until the result slot
//   frees, and s_tready drops behind it.
// ============================================================================
module decimal_text_to_int16
    import dtoi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] number_bits
    output logic [0:0]  m_tuser,   // [0] parse_ok
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic              signed_mode_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_end_reg;
    parse_state_t      st_reg;
    parse_state_t      st_next;
    logic              out_valid_reg;
    logic [NUM_W-1:0]  out_num_reg;
    logic              out_ok_reg;
    logic [NUM_W-1:0]  num_next;
    logic              ok_next;
    logic              advance;
    logic              step_en;

    dtoi_char_step u_step (
        .st          (st_reg),
        .char_code   (in_char_reg),
        .end_mark    (in_end_reg),
        .signed_mode (signed_mode_reg),
        .st_next     (st_next),
        .number_bits (num_next),
        .parse_ok    (ok_next)
    );

    assign advance  = !(in_end_reg && out_valid_reg && !m_tready);
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_num_reg;
    assign m_tuser[0] = out_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
            in_valid_reg    <= 1'b0;
            st_reg          <= PARSE_CLEAR;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                signed_mode_reg <= cfg_wdata;

            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (step_en)
                st_reg <= st_next;

            if (step_en && in_end_reg)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (step_en && in_end_reg)
        begin
            out_num_reg <= num_next;
            out_ok_reg  <= ok_next;
        end
    end

    a_char_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !(in_valid_reg && in_end_reg) |=> !out_valid_reg)
        else $error("result raised without an end item");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted item not held in input register");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && in_end_reg |=> st_reg.at_start && !st_reg.failed && st_reg.acc == '0)
        else $error("parse state not cleared after end item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && in_end_reg && $stable(st_reg))
        else $error("stalled end item lost or state moved");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && in_end_reg && !ok_next |=> out_num_reg == '0)
        else $error("failed parse gave nonzero value");

endmodule
